FILE: design/msi_coherent_line_controller_assert.svh
// Assertion macros for the MSI coherent line controller.
`ifndef MSI_COHERENT_LINE_CONTROLLER_ASSERT_SVH
`define MSI_COHERENT_LINE_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mclc check failed in same cycle");

// Consequent must hold in the cycle after the antecedent.
`define MCLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mclc check failed in next cycle");

`endif

FILE: design/mclc_pkg.sv
// Types and codes shared by the MSI coherent line controller.
`default_nettype none

package mclc_pkg;

    localparam int ADDR_W = 32;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0]
    {
        ACT_CPU_REQ  = 2'd0,
        ACT_BUS_GNT  = 2'd1,
        ACT_MEM_RESP = 2'd2,
        ACT_SNOOP    = 2'd3
    } action_t;

    typedef enum logic [1:0]
    {
        ST_INVALID  = 2'd0,
        ST_SHARED   = 2'd1,
        ST_MODIFIED = 2'd2
    } line_state_t;

    // Result word, lowest bit last in this list (packed MSB first).
    typedef struct packed
    {
        logic              pad;
        logic              busy_res;
        logic              bus_release;
        logic [BYTE_W-1:0] writeback_data;
        logic [ADDR_W-1:0] writeback_address;
        logic              writeback_valid;
        logic [BYTE_W-1:0] mem_req_data;
        logic [ADDR_W-1:0] mem_req_address;
        logic              mem_req_read;
        logic              mem_req_valid;
        logic              bus_request;
        logic [BYTE_W-1:0] cpu_resp_data;
        logic              cpu_resp_valid;
    } result_t;

endpackage

`default_nettype wire

FILE: design/msi_coherent_line_controller.sv
// MSI snooping coherence controller for a single cached line.
//
// Usage:
//   Slave stream carries one event per request: tuser selects the kind
//   (cpu request, bus grant, memory response, snoop), tdata carries the
//   address, the read flag and a data byte. Master stream returns exactly
//   one result per request: cpu response, bus request, memory request,
//   writeback, bus release and the busy flag, packed into 96 bits.
//   Pipeline: a request is captured in the input register, evaluated
//   against the line state and registered in the result register, from
//   which the master side presents it. Throughput: one request per cycle
//   while the master side keeps taking results; the line state is
//   updated in the same cycle the result is registered, so the next request
//   sees it at once.
//   Reset (rst_n low, asynchronous): line Invalid, tag, data, dirty bit and
//   pending request cleared, not busy, both pipeline registers empty.
//   Receiver stall: the result register holds its word, the input register
//   can still take one more request, then tready drops until the master
//   side drains.
`default_nettype none

module msi_coherent_line_controller #(
    parameter int ADDR_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: address[31:0], is_read[32], data_byte[40:33], zero[47:41]
    input  wire logic [47:0] s_axis_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: cpu_resp_valid[0], cpu_resp_data[8:1], bus_request[9],
    // mem_req_valid[10], mem_req_read[11], mem_req_address[43:12],
    // mem_req_data[51:44], writeback_valid[52], writeback_address[84:53],
    // writeback_data[92:85], bus_release[93], busy_res[94], zero[95]
    output logic [95:0]      m_axis_tdata
);

    // Bits of the address that are kept in the tag and pending registers.
    localparam int KEEP_W = (ADDR_BITS < mclc_pkg::ADDR_W) ? ADDR_BITS : mclc_pkg::ADDR_W;

    // Input register: holds one captured request.
    logic                          in_valid_reg;
    mclc_pkg::action_t             in_action_reg;
    logic [mclc_pkg::ADDR_W-1:0]   in_address_reg;
    logic                          in_read_reg;
    logic [mclc_pkg::BYTE_W-1:0]   in_byte_reg;

    // Line and pending-request state.
    mclc_pkg::line_state_t         line_state_reg, line_state_next;
    logic [KEEP_W-1:0]             line_tag_reg, line_tag_next;
    logic                          line_dirty_reg, line_dirty_next;
    logic [mclc_pkg::BYTE_W-1:0]   line_data_reg, line_data_next;
    logic [KEEP_W-1:0]             pending_address_reg, pending_address_next;
    logic                          pending_read_reg, pending_read_next;
    logic [mclc_pkg::BYTE_W-1:0]   pending_data_reg, pending_data_next;
    logic                          blocked_flag_reg, blocked_flag_next;

    // Result register.
    logic                          out_valid_reg;
    mclc_pkg::result_t             out_reg;
    mclc_pkg::result_t             res_next;

    logic                          advance;
    logic [KEEP_W-1:0]             addr_kept;
    logic                          line_valid;
    logic                          hit;

    // Evaluate the captured request when the result register is free.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign addr_kept  = in_address_reg[KEEP_W-1:0];
    // State code 3 is never written and reads as Invalid.
    assign line_valid = (line_state_reg == mclc_pkg::ST_SHARED)
                     || (line_state_reg == mclc_pkg::ST_MODIFIED);
    assign hit        = line_valid && (line_tag_reg == addr_kept);

    always_comb
    begin
        line_state_next      = line_state_reg;
        line_tag_next        = line_tag_reg;
        line_dirty_next      = line_dirty_reg;
        line_data_next       = line_data_reg;
        pending_address_next = pending_address_reg;
        pending_read_next    = pending_read_reg;
        pending_data_next    = pending_data_reg;
        blocked_flag_next    = blocked_flag_reg;
        res_next             = '0;

        case (in_action_reg)
            mclc_pkg::ACT_CPU_REQ:
            begin
                // Drop cpu requests while a miss or upgrade is outstanding.
                if (!blocked_flag_reg)
                begin
                    blocked_flag_next = 1'b1;
                    if (hit)
                    begin
                        if (in_read_reg)
                        begin
                            res_next.cpu_resp_valid = 1'b1;
                            res_next.cpu_resp_data  = line_data_reg;
                            blocked_flag_next       = 1'b0;
                        end
                        else if (line_state_reg == mclc_pkg::ST_MODIFIED)
                        begin
                            line_dirty_next         = 1'b1;
                            line_data_next          = in_byte_reg;
                            res_next.cpu_resp_valid = 1'b1;
                            blocked_flag_next       = 1'b0;
                        end
                        else
                        begin
                            // Upgrade from Shared: line goes Modified now,
                            // data lands with the memory response.
                            line_dirty_next       = 1'b1;
                            pending_address_next  = addr_kept;
                            pending_read_next     = 1'b0;
                            pending_data_next     = in_byte_reg;
                            line_state_next       = mclc_pkg::ST_MODIFIED;
                            res_next.bus_request  = 1'b1;
                        end
                    end
                    else
                    begin
                        pending_address_next = addr_kept;
                        pending_read_next    = in_read_reg;
                        if (!in_read_reg)
                        begin
                            pending_data_next = in_byte_reg;
                        end
                        res_next.bus_request = 1'b1;
                    end
                end
            end
            mclc_pkg::ACT_BUS_GNT:
            begin
                if (blocked_flag_reg)
                begin
                    res_next.mem_req_valid   = 1'b1;
                    res_next.mem_req_read    = pending_read_reg;
                    res_next.mem_req_address = mclc_pkg::ADDR_W'(pending_address_reg);
                    res_next.mem_req_data    = pending_read_reg ? '0 : pending_data_reg;
                end
            end
            mclc_pkg::ACT_MEM_RESP:
            begin
                if (blocked_flag_reg)
                begin
                    // Write back a dirty victim with another tag.
                    if (line_dirty_reg && line_valid && (line_tag_reg != addr_kept))
                    begin
                        res_next.writeback_valid   = 1'b1;
                        res_next.writeback_address = mclc_pkg::ADDR_W'(line_tag_reg);
                        res_next.writeback_data    = line_data_reg;
                    end
                    line_tag_next = addr_kept;
                    if (in_read_reg)
                    begin
                        line_state_next        = mclc_pkg::ST_SHARED;
                        line_data_next         = in_byte_reg;
                        line_dirty_next        = 1'b0;
                        res_next.cpu_resp_data = in_byte_reg;
                    end
                    else
                    begin
                        line_state_next = mclc_pkg::ST_MODIFIED;
                        line_data_next  = pending_data_reg;
                        line_dirty_next = 1'b1;
                    end
                    res_next.cpu_resp_valid = 1'b1;
                    res_next.bus_release    = 1'b1;
                    blocked_flag_next       = 1'b0;
                end
            end
            mclc_pkg::ACT_SNOOP:
            begin
                // Snoops are served whether busy or not.
                if (hit && ((line_state_reg == mclc_pkg::ST_MODIFIED) || !in_read_reg))
                begin
                    if (line_dirty_reg)
                    begin
                        res_next.writeback_valid   = 1'b1;
                        res_next.writeback_address = mclc_pkg::ADDR_W'(line_tag_reg);
                        res_next.writeback_data    = line_data_reg;
                        line_dirty_next            = 1'b0;
                    end
                    line_state_next = mclc_pkg::ST_INVALID;
                end
            end
            default:
            begin
                line_state_next = line_state_reg;
            end
        endcase

        res_next.busy_res = blocked_flag_next;
    end

    // Control and line state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            line_state_reg      <= mclc_pkg::ST_INVALID;
            line_tag_reg        <= '0;
            line_dirty_reg      <= 1'b0;
            line_data_reg       <= '0;
            pending_address_reg <= '0;
            pending_read_reg    <= 1'b0;
            pending_data_reg    <= '0;
            blocked_flag_reg    <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                line_state_reg      <= line_state_next;
                line_tag_reg        <= line_tag_next;
                line_dirty_reg      <= line_dirty_next;
                line_data_reg       <= line_data_next;
                pending_address_reg <= pending_address_next;
                pending_read_reg    <= pending_read_next;
                pending_data_reg    <= pending_data_next;
                blocked_flag_reg    <= blocked_flag_next;
            end
        end
    end

    // Payload registers: capture on handshake, no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg  <= mclc_pkg::action_t'(s_axis_tuser);
            in_address_reg <= s_axis_tdata[31:0];
            in_read_reg    <= s_axis_tdata[32];
            in_byte_reg    <= s_axis_tdata[40:33];
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

`include "msi_coherent_line_controller_assert.svh"

    // A writeback only ever leaves a dirty line.
    `MCLC_ASSERT_NOW(a_wb_dirty, advance && res_next.writeback_valid, line_dirty_reg && line_valid)
    // A bus request leaves the controller blocked.
    `MCLC_ASSERT_NEXT(a_req_blocks, advance && res_next.bus_request, blocked_flag_reg)
    // A bus release always completes the cpu request and unblocks.
    `MCLC_ASSERT_NOW(a_release_done, advance && res_next.bus_release, res_next.cpu_resp_valid && !res_next.busy_res)
    // Reported busy flag tracks the stored one.
    `MCLC_ASSERT_NEXT(a_busy_track, advance, out_reg.busy_res == blocked_flag_reg)

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the single-line MSI snooping controller: directed table then random traffic.
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEMS_TOTAL = 1650;
    localparam int IDLE_PCT    = 17;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 8;

    typedef struct
    {
        mclc_pkg::action_t act;
        logic [31:0]       addr;
        logic              rd;
        logic [7:0]        data;
        bit                typed;
        mclc_pkg::result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    // Line and miss tracking used to work out the result of every request.
    mclc_pkg::line_state_t cached_state;
    logic [31:0]           cached_tag;
    logic                  cached_dirty;
    logic [7:0]            cached_byte;
    logic [31:0]           miss_addr;
    logic                  miss_is_read;
    logic [7:0]            miss_byte;
    logic                  ctrl_busy;

    mclc_pkg::result_t awaited_results[$];
    stim_row_t         directed_rows[$];
    int                mismatch_count = 0;
    int                sent_count     = 0;
    int                results_seen   = 0;
    bit                send_gaps      = 1'b1;
    bit                recv_gaps      = 1'b1;
    bit                hold_req       = 1'b0;

    msi_coherent_line_controller #(
        .ADDR_BITS(32)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s got %h expected %h",
                                      results_seen, name, got, want));
    endtask

    // Advance the line state by one request and return the result it should produce.
    function automatic mclc_pkg::result_t predict_line_event(mclc_pkg::action_t act,
                                                             logic [31:0] addr,
                                                             logic rd, logic [7:0] data);
        mclc_pkg::result_t r;
        logic              hit;
        r   = '0;
        hit = (cached_state == mclc_pkg::ST_SHARED || cached_state == mclc_pkg::ST_MODIFIED) &&
              cached_tag == addr;
        case (act)
            mclc_pkg::ACT_CPU_REQ:
                if (!ctrl_busy)
                begin
                    ctrl_busy = 1'b1;
                    if (hit && rd)
                    begin
                        r.cpu_resp_valid = 1'b1;
                        r.cpu_resp_data  = cached_byte;
                        ctrl_busy        = 1'b0;
                    end
                    else if (hit && cached_state == mclc_pkg::ST_MODIFIED)
                    begin
                        cached_dirty     = 1'b1;
                        cached_byte      = data;
                        r.cpu_resp_valid = 1'b1;
                        ctrl_busy        = 1'b0;
                    end
                    else if (hit)
                    begin
                        // Upgrade from Shared: Modified and dirty now, data lands later.
                        cached_dirty  = 1'b1;
                        miss_addr     = addr;
                        miss_is_read  = 1'b0;
                        miss_byte     = data;
                        cached_state  = mclc_pkg::ST_MODIFIED;
                        r.bus_request = 1'b1;
                    end
                    else
                    begin
                        miss_addr    = addr;
                        miss_is_read = rd;
                        if (!rd)
                            miss_byte = data;
                        r.bus_request = 1'b1;
                    end
                end
            mclc_pkg::ACT_BUS_GNT:
                if (ctrl_busy)
                begin
                    r.mem_req_valid   = 1'b1;
                    r.mem_req_read    = miss_is_read;
                    r.mem_req_address = miss_addr;
                    r.mem_req_data    = miss_is_read ? 8'h00 : miss_byte;
                end
            mclc_pkg::ACT_MEM_RESP:
                if (ctrl_busy)
                begin
                    if (cached_dirty && cached_tag != addr &&
                        (cached_state == mclc_pkg::ST_SHARED ||
                         cached_state == mclc_pkg::ST_MODIFIED))
                    begin
                        r.writeback_valid   = 1'b1;
                        r.writeback_address = cached_tag;
                        r.writeback_data    = cached_byte;
                    end
                    cached_tag = addr;
                    if (rd)
                    begin
                        cached_state    = mclc_pkg::ST_SHARED;
                        cached_byte     = data;
                        cached_dirty    = 1'b0;
                        r.cpu_resp_data = data;
                    end
                    else
                    begin
                        cached_state = mclc_pkg::ST_MODIFIED;
                        cached_byte  = miss_byte;
                        cached_dirty = 1'b1;
                    end
                    r.cpu_resp_valid = 1'b1;
                    r.bus_release    = 1'b1;
                    ctrl_busy        = 1'b0;
                end
            mclc_pkg::ACT_SNOOP:
                if (hit && (cached_state == mclc_pkg::ST_MODIFIED || !rd))
                begin
                    if (cached_dirty)
                    begin
                        r.writeback_valid   = 1'b1;
                        r.writeback_address = cached_tag;
                        r.writeback_data    = cached_byte;
                        cached_dirty        = 1'b0;
                    end
                    cached_state = mclc_pkg::ST_INVALID;
                end
            default:
                r = '0;
        endcase
        r.busy_res = ctrl_busy;
        return r;
    endfunction

    // Offer one request, hold it until accepted, then queue what it should produce.
    task automatic offer_request(mclc_pkg::action_t act, logic [31:0] addr, logic rd,
                                 logic [7:0] data, bit typed,
                                 mclc_pkg::result_t typed_want);
        mclc_pkg::result_t predicted;
        while (send_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, data, rd, addr};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = predict_line_event(act, addr, rd, data);
        awaited_results.push_back(typed ? typed_want : predicted);
        sent_count++;
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_address();
        case ($urandom_range(9))
            0, 1:    return 32'h0000_0000;
            2, 3:    return 32'hFFFF_FFFF;
            4, 5:    return 32'h8000_0000;
            6, 7:    return 32'h5555_AAAA;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(mclc_pkg::action_t act, logic [31:0] addr, logic rd,
                           logic [7:0] data, bit typed, mclc_pkg::result_t want);
        stim_row_t row;
        row.act   = act;
        row.addr  = addr;
        row.rd    = rd;
        row.data  = data;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= recv_gaps ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    // Compare every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        mclc_pkg::result_t got;
        mclc_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("result with nothing expected: %h", got));
            else
            begin
                want = awaited_results.pop_front();
                check_field("cpu_resp_valid", 32'(got.cpu_resp_valid),
                            32'(want.cpu_resp_valid));
                check_field("cpu_resp_data", 32'(got.cpu_resp_data),
                            32'(want.cpu_resp_data));
                check_field("bus_request", 32'(got.bus_request), 32'(want.bus_request));
                check_field("mem_req_valid", 32'(got.mem_req_valid),
                            32'(want.mem_req_valid));
                check_field("mem_req_read", 32'(got.mem_req_read), 32'(want.mem_req_read));
                check_field("mem_req_address", got.mem_req_address, want.mem_req_address);
                check_field("mem_req_data", 32'(got.mem_req_data), 32'(want.mem_req_data));
                check_field("writeback_valid", 32'(got.writeback_valid),
                            32'(want.writeback_valid));
                check_field("writeback_address", got.writeback_address,
                            want.writeback_address);
                check_field("writeback_data", 32'(got.writeback_data),
                            32'(want.writeback_data));
                check_field("bus_release", 32'(got.bus_release), 32'(want.bus_release));
                check_field("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                check_field("pad", 32'(got.pad), 32'(want.pad));
            end
            results_seen++;
        end
    end

    // Stimulus: reset, directed table, random traffic, drain and verdict.
    initial
    begin
        mclc_pkg::result_t e;
        int                roll;
        bit                hold_done;
        bit                drain_done;

        hold_done  = 1'b0;
        drain_done = 1'b0;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mclc_pkg::ACT_CPU_REQ;

        cached_state = mclc_pkg::ST_INVALID;
        cached_tag   = '0;
        cached_dirty = 1'b0;
        cached_byte  = '0;
        miss_addr    = '0;
        miss_is_read = 1'b0;
        miss_byte    = '0;
        ctrl_busy    = 1'b0;

        // Idle line after reset: grant, memory response and snoop are all ignored.
        e = '0;
        add_row(mclc_pkg::ACT_BUS_GNT, 32'h0000_0000, 1'b1, 8'h00, 1'b1, e);
        add_row(mclc_pkg::ACT_MEM_RESP, 32'h0000_0000, 1'b1, 8'hFF, 1'b1, e);
        add_row(mclc_pkg::ACT_SNOOP, 32'h0000_0000, 1'b0, 8'h00, 1'b1, e);
        // Read miss at the top address asks for the bus.
        e = '0;
        e.bus_request = 1'b1;
        e.busy_res    = 1'b1;
        add_row(mclc_pkg::ACT_CPU_REQ, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1, e);
        // Cpu request while blocked: only the busy flag comes back.
        e = '0;
        e.busy_res = 1'b1;
        add_row(mclc_pkg::ACT_CPU_REQ, 32'h0000_0000, 1'b0, 8'hFF, 1'b1, e);
        e = '0;
        e.mem_req_valid   = 1'b1;
        e.mem_req_read    = 1'b1;
        e.mem_req_address = 32'hFFFF_FFFF;
        e.busy_res        = 1'b1;
        add_row(mclc_pkg::ACT_BUS_GNT, 32'h0000_0000, 1'b0, 8'h00, 1'b1, e);
        e = '0;
        e.cpu_resp_valid = 1'b1;
        e.cpu_resp_data  = 8'hFF;
        e.bus_release    = 1'b1;
        add_row(mclc_pkg::ACT_MEM_RESP, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, e);
        // Hits, upgrade from Shared, snoop on a dirty line mid-upgrade.
        add_row(mclc_pkg::ACT_CPU_REQ, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_SNOOP, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_CPU_REQ, 32'hFFFF_FFFF, 1'b0, 8'hA5, 1'b0, '0);
        add_row(mclc_pkg::ACT_SNOOP, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_BUS_GNT, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0, '0);
        add_row(mclc_pkg::ACT_MEM_RESP, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_CPU_REQ, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_CPU_REQ, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0, '0);
        // Miss replacing a dirty Modified line forces a writeback on allocation.
        add_row(mclc_pkg::ACT_CPU_REQ, 32'h0000_0000, 1'b1, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_BUS_GNT, 32'h0000_0000, 1'b1, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_MEM_RESP, 32'h0000_0000, 1'b1, 8'h5A, 1'b0, '0);
        add_row(mclc_pkg::ACT_SNOOP, 32'h0000_0000, 1'b0, 8'h00, 1'b0, '0);
        // Write miss, then a snoop read that hits Modified.
        add_row(mclc_pkg::ACT_CPU_REQ, 32'h8000_0000, 1'b0, 8'h3C, 1'b0, '0);
        add_row(mclc_pkg::ACT_BUS_GNT, 32'h8000_0000, 1'b0, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_MEM_RESP, 32'h8000_0000, 1'b0, 8'h00, 1'b0, '0);
        add_row(mclc_pkg::ACT_SNOOP, 32'h8000_0000, 1'b1, 8'h00, 1'b0, '0);
        // Read miss answered by a write response: the old pending byte is allocated.
        add_row(mclc_pkg::ACT_CPU_REQ, 32'h1234_5678, 1'b1, 8'hFF, 1'b0, '0);
        add_row(mclc_pkg::ACT_MEM_RESP, 32'h1234_5678, 1'b0, 8'hC3, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i].act, directed_rows[i].addr, directed_rows[i].rd,
                          directed_rows[i].data, directed_rows[i].typed,
                          directed_rows[i].want);

        while (sent_count < ITEMS_TOTAL)
        begin
            // Long receiver hold-off while requests keep coming, to fill the pipeline.
            if (sent_count >= 300 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            // Sender pause until the block has returned everything.
            if (sent_count >= 700 && !drain_done)
            begin
                drain_done = 1'b1;
                wait_for_results();
            end
            // Full-rate stretch with no idling on either side.
            send_gaps = !(sent_count >= 900 && sent_count < 1150);
            recv_gaps = send_gaps;

            roll = $urandom_range(99);
            if (roll < 8)
                offer_request(mclc_pkg::action_t'($urandom_range(3)), $urandom,
                              1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, '0);
            else if (roll < 22)
                offer_request(mclc_pkg::ACT_SNOOP, pick_address(), 1'($urandom_range(1)),
                              8'($urandom_range(255)), 1'b0, '0);
            else if (!ctrl_busy)
                offer_request(mclc_pkg::ACT_CPU_REQ, pick_address(), 1'($urandom_range(1)),
                              8'($urandom_range(255)), 1'b0, '0);
            else
            begin
                // Complete the outstanding miss: grant, then the memory response.
                offer_request(mclc_pkg::ACT_BUS_GNT, $urandom, 1'($urandom_range(1)),
                              8'($urandom_range(255)), 1'b0, '0);
                offer_request(mclc_pkg::ACT_MEM_RESP,
                              ($urandom_range(9) != 0) ? miss_addr : pick_address(),
                              ($urandom_range(6) != 0) ? miss_is_read
                                                       : 1'($urandom_range(1)),
                              8'($urandom_range(255)), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
